// ===== rtl/positional_list_store_macros.svh =====
// Assertion macros used by the positional list store RTL.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define PLS_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define PLS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pls_pkg.sv =====
// Package with the sizes, codes and control types of the positional list store.
`default_nettype none

package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int POS_W = 7;
    localparam int LEN_W = 7;
    localparam int DATA_W = 32;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK = 3'd1;
    localparam logic [2:0] OP_INS_AT = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_BACK = 3'd4;
    localparam logic [2:0] OP_DEL_AT = 3'd5;
    localparam logic [2:0] OP_READ_AT = 3'd6;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             rd;
        logic [CMP_W-1:0] tgt;
    } pls_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
// Top level of the positional list store: controller and a chain of value cells.
//
//   Port group   Direction   Transfer
//   command      in          start && !busy: op, item_value, position
//   result       out         done (one cycle): status, list_length, read_value
//
// Each command has a capture cycle and then an execute cycle, in which every cell
// compares its index with the target and shifts, loads or holds at once.
// The result strobe comes in the cycle after the execute cycle, when busy is
// already low again, so a new command may be taken in that same cycle.
// Reset empties the list; cell contents are not cleared and are never read
// before being written. The result side has no stall.
`default_nettype none

module positional_list_store
    import pls_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [2:0]               op,
    input  wire logic signed [DATA_W-1:0] item_value,
    input  wire logic [POS_W-1:0]         position,
    output logic                          busy,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [LEN_W-1:0]              list_length,
    output logic signed [DATA_W-1:0]      read_value
);

    pls_ctrl_t                ctrl;
    logic signed [DATA_W-1:0] new_value;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic signed [DATA_W-1:0] cell_read [CAPACITY];

    pls_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .item_value  (item_value),
        .position    (position),
        .rd_data     (rd_data),
        .busy        (busy),
        .ctrl        (ctrl),
        .new_value   (new_value),
        .done        (done),
        .status      (status),
        .list_length (list_length),
        .read_value  (read_value)
    );

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;

        if (k == 0)
        begin : g_first
            assign left_value = '0;
        end
        else
        begin : g_left
            assign left_value = cell_value[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_right
            assign right_value = cell_value[k+1];
        end

        pls_cell u_cell (
            .clk         (clk),
            .cell_index  (IDX_W'(k)),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[k]),
            .read_out    (cell_read[k])
        );
    end

    // At most one cell drives a nonzero read word, so an OR merges them.
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_data = rd_data | cell_read[i];
        end
    end

`include "positional_list_store_macros.svh"

    `PLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not set busy")
    `PLS_ASSERT_NEXT(a_busy_done, busy, done && !busy, "execute cycle gave no result")
    `PLS_ASSERT_ALWAYS(a_len_cap, !done || list_length <= LEN_W'(CAPACITY), "length over capacity")
    `PLS_ASSERT_ALWAYS(a_read_zero, !done || status == ST_DONE || read_value == '0, "ignored read gave data")

endmodule

`default_nettype wire

// ===== rtl/pls_cell.sv =====
// One storage cell of the list chain, with its shift and read logic.
`default_nettype none

module pls_cell
    import pls_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic [IDX_W-1:0]         cell_index,
    input  wire pls_ctrl_t                ctrl,
    input  wire logic signed [DATA_W-1:0] new_value,
    input  wire logic signed [DATA_W-1:0] left_value,
    input  wire logic signed [DATA_W-1:0] right_value,
    output logic signed [DATA_W-1:0]      value,
    output logic signed [DATA_W-1:0]      read_out
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic [CMP_W-1:0]         here;

    assign here = CMP_W'(cell_index);

    // An insert pushes cells behind the target one step back; a delete pulls
    // cells from the target on one step forward.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (here > ctrl.tgt)
            begin
                value_next = left_value;
            end
            else if (here == ctrl.tgt)
            begin
                value_next = new_value;
            end
        end
        else if (ctrl.del)
        begin
            if (here >= ctrl.tgt)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign read_out = (ctrl.rd && here == ctrl.tgt) ? value_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/pls_ctrl.sv =====
// Controller: takes commands, checks them against the length, drives the chain.
`default_nettype none

module pls_ctrl
    import pls_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [2:0]               op,
    input  wire logic signed [DATA_W-1:0] item_value,
    input  wire logic [POS_W-1:0]         position,
    input  wire logic signed [DATA_W-1:0] rd_data,
    output logic                          busy,
    output pls_ctrl_t                     ctrl,
    output logic signed [DATA_W-1:0]      new_value,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [LEN_W-1:0]              list_length,
    output logic signed [DATA_W-1:0]      read_value
);

    logic                     busy_reg;
    logic [2:0]               op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         len_reg;
    logic [CNT_W-1:0]         len_next;
    logic                     done_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [LEN_W-1:0]         list_length_reg;
    logic signed [DATA_W-1:0] read_value_reg;

    logic [CMP_W-1:0] len_c;
    logic [CMP_W-1:0] pos_c;
    logic             is_full;
    logic             is_empty;
    logic             pos_bad_ins;
    logic             pos_bad_old;

    assign len_c = CMP_W'(len_reg);
    assign pos_c = CMP_W'(pos_reg);
    assign is_full = (len_reg >= CNT_W'(CAPACITY));
    assign is_empty = (len_reg == '0);
    assign pos_bad_ins = (pos_c == '0) || (pos_c > len_c + CMP_W'(1));
    assign pos_bad_old = (pos_c == '0) || (pos_c > len_c);

    always_comb
    begin
        ctrl = '0;
        status_next = ST_DONE;
        len_next = len_reg;
        case (op_reg)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else if (op_reg == OP_INS_AT && pos_bad_ins)
                begin
                    status_next = ST_IGNORED;
                end
                else
                begin
                    ctrl.ins = 1'b1;
                    len_next = len_reg + CNT_W'(1);
                    if (op_reg == OP_INS_BACK)
                    begin
                        ctrl.tgt = len_c;
                    end
                    else if (op_reg == OP_INS_AT)
                    begin
                        ctrl.tgt = pos_c - CMP_W'(1);
                    end
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (is_empty)
                begin
                    status_next = ST_IGNORED;
                end
                else
                begin
                    ctrl.del = 1'b1;
                    len_next = len_reg - CNT_W'(1);
                    if (op_reg == OP_DEL_BACK)
                    begin
                        ctrl.tgt = len_c - CMP_W'(1);
                    end
                end
            end
            OP_DEL_AT, OP_READ_AT:
            begin
                if (pos_bad_old)
                begin
                    status_next = ST_IGNORED;
                end
                else
                begin
                    ctrl.tgt = pos_c - CMP_W'(1);
                    if (op_reg == OP_DEL_AT)
                    begin
                        ctrl.del = 1'b1;
                        len_next = len_reg - CNT_W'(1);
                    end
                    else
                    begin
                        ctrl.rd = 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase
        // The chain only moves in the execute cycle.
        if (!busy_reg)
        begin
            ctrl.ins = 1'b0;
            ctrl.del = 1'b0;
            ctrl.rd = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            len_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                busy_reg <= 1'b0;
                len_reg <= len_next;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            op_reg <= op;
            val_reg <= item_value;
            pos_reg <= position;
        end
        if (busy_reg)
        begin
            status_reg <= status_next;
            list_length_reg <= LEN_W'(len_next);
            read_value_reg <= rd_data;
        end
    end

    assign busy = busy_reg;
    assign new_value = val_reg;
    assign done = done_reg;
    assign status = status_reg;
    assign list_length = list_length_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire
